@@ hdl/time_of_day_offset_compare_top_defines.svh @@
// Assertion macros used by the time-of-day offset/compare top level.
`ifndef TIME_OF_DAY_OFFSET_COMPARE_TOP_DEFINES_SVH
`define TIME_OF_DAY_OFFSET_COMPARE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TODOC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TODOC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/todoc_pkg.sv @@
// Types and constants for the time-of-day offset/compare block.
package todoc_pkg;

    localparam int NSTAGE = 7;          // pipeline depth, input reg to result reg

    localparam int HOURS_W = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int OFF_W   = 31;
    localparam int TOD_W   = 17;        // second of day, also holds 31*3600+63*60+63
    localparam int SUM_W   = 18;        // tod +/- offset before wrap
    localparam int Q_W     = 15;        // offset / 86400 fits 15 bits
    localparam int TMIN_W  = 11;        // minute of day, 0..1439
    localparam int ORDER_W = 2;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 32;

    localparam logic [TOD_W-1:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [TOD_W-1:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [TOD_W-1:0] SEC_PER_MIN  = 17'd60;

    localparam logic [HOURS_W-1:0] HOURS_PER_DAY = 5'd24;
    localparam logic [HOURS_W-1:0] HALF_DAY_HRS  = 5'd12;
    localparam logic [MIN_W-1:0]   MIN_LIMIT     = 6'd60;
    localparam logic [SEC_W-1:0]   SEC_LIMIT     = 6'd60;

    // floor reciprocal of one day; estimate is low by at most one
    localparam int              DAY_RECIP_SH = 48;
    localparam logic [31:0]     DAY_RECIP    = 32'((64'd1 << 48) / 64'd86400);
    // ceiling reciprocals, exact for any second of day
    localparam int              HOUR_RECIP_SH = 30;
    localparam logic [18:0]     HOUR_RECIP    = 19'(((64'd1 << 30) + 64'd3599) / 64'd3600);
    localparam int              MIN_RECIP_SH  = 24;
    localparam logic [18:0]     MIN_RECIP     = 19'(((64'd1 << 24) + 64'd59) / 64'd60);

    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_SUB = 1'b1;

    localparam logic [ORDER_W-1:0] ORD_LESS    = 2'd0;
    localparam logic [ORDER_W-1:0] ORD_EQUAL   = 2'd1;
    localparam logic [ORDER_W-1:0] ORD_GREATER = 2'd2;

    // per-stage load strobes from the handshake control
    typedef struct packed {
        logic [NSTAGE-1:0] load;
    } todoc_adv_t;

    // flags about A, worked out early and carried down the pipe
    typedef struct packed {
        logic                 a_valid;
        logic [ORDER_W-1:0]   order;
        logic [HOURS_W-1:0]   hour_twelve;
        logic                 is_pm;
    } todoc_flags_t;

endpackage

@@ hdl/time_of_day_offset_compare_top.sv @@
// Top level of the time-of-day offset/compare block: stream ports and pipe control.
//
//  Port group  Dir  Payload
//  s_axis      in   tdata: A h/m/s, offset, B h/m/s; tuser: func
//  m_axis      out  tdata: result h/m/s, a_valid, order, hour_twelve, is_pm
//
//  One item per cycle sustained while m_axis_tready is high. Depth is set by
//  the constant-reciprocal multiplies (offset / day, result / 3600, result /
//  60), each followed by a register. rst_n clears only the stage valid bits;
//  data registers are not reset. A stalled m_axis holds its item; stages
//  behind it keep filling until the pipe is full, and only then does
//  s_axis_tready drop.
`include "time_of_day_offset_compare_top_defines.svh"

module time_of_day_offset_compare_top
    import todoc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // [4:0] a_hours, [10:5] a_minutes, [16:11] a_seconds, [47:17] offset_seconds,
    // [52:48] b_hours, [58:53] b_minutes, [64:59] b_seconds, [71:65] zero
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] func: 0 add, 1 subtract
    input  logic                    s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [4:0] res_hours, [10:5] res_minutes, [16:11] res_seconds, [17] a_valid,
    // [19:18] order, [24:20] hour_twelve, [25] is_pm, [31:26] zero
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

    logic [NSTAGE-1:0]  v_reg, v_next;
    logic [NSTAGE-1:0]  rdy;
    todoc_adv_t         adv;
    logic [HOURS_W-1:0] res_hours;
    logic [MIN_W-1:0]   res_minutes;
    logic [SEC_W-1:0]   res_seconds;
    todoc_flags_t       flags;
    logic               in_acc, out_acc;

    // A stage may load when it is empty or its content moves on this cycle.
    always_comb
    begin
        rdy[NSTAGE-1] = !v_reg[NSTAGE-1] || m_axis_tready;
        for (int k = NSTAGE - 2; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    always_comb
    begin
        v_next[0] = rdy[0] ? s_axis_tvalid : v_reg[0];
        for (int k = 1; k < NSTAGE; k++)
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign adv.load = rdy;

    todoc_datapath u_datapath (
        .clk            (clk),
        .adv            (adv),
        .func           (s_axis_tuser),
        .a_hours        (s_axis_tdata[4:0]),
        .a_minutes      (s_axis_tdata[10:5]),
        .a_seconds      (s_axis_tdata[16:11]),
        .offset_seconds (s_axis_tdata[47:17]),
        .b_hours        (s_axis_tdata[52:48]),
        .b_minutes      (s_axis_tdata[58:53]),
        .b_seconds      (s_axis_tdata[64:59]),
        .res_hours      (res_hours),
        .res_minutes    (res_minutes),
        .res_seconds    (res_seconds),
        .flags          (flags)
    );

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = v_reg[NSTAGE-1];
    assign m_axis_tdata  = {6'd0, flags.is_pm, flags.hour_twelve, flags.order, flags.a_valid,
                            res_seconds, res_minutes, res_hours};

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // wrapped result is always a proper time of day
    `TODOC_ASSERT_NOW(a_res_range, m_axis_tvalid,
        (res_hours < HOURS_PER_DAY) && (res_minutes < MIN_LIMIT) && (res_seconds < SEC_LIMIT),
        "result time out of range")
    // compare code is one of less, equal, greater
    `TODOC_ASSERT_NOW(a_order_code, m_axis_tvalid,
        (flags.order == ORD_LESS) || (flags.order == ORD_EQUAL) || (flags.order == ORD_GREATER),
        "bad order code")
    // input side only stalls with every stage full
    `TODOC_ASSERT_NOW(a_no_early_stall, $countones(v_reg) != NSTAGE, s_axis_tready,
        "input stalled with room in pipe")
    // items in flight change only by accepts on either side
    `TODOC_ASSERT_NEXT(a_occupancy, 1'b1,
        $countones(v_reg) == $past($countones(v_reg)) + $past(int'(in_acc))
            - $past(int'(out_acc)),
        "item lost or duplicated in pipe")

endmodule

@@ hdl/todoc_datapath.sv @@
// Pipelined datapath: offset mod day, add/subtract with wrap, split to h/m/s.
module todoc_datapath
    import todoc_pkg::*;
(
    input  logic                 clk,
    input  todoc_adv_t           adv,
    input  logic                 func,
    input  logic [HOURS_W-1:0]   a_hours,
    input  logic [MIN_W-1:0]     a_minutes,
    input  logic [SEC_W-1:0]     a_seconds,
    input  logic [OFF_W-1:0]     offset_seconds,
    input  logic [HOURS_W-1:0]   b_hours,
    input  logic [MIN_W-1:0]     b_minutes,
    input  logic [SEC_W-1:0]     b_seconds,
    output logic [HOURS_W-1:0]   res_hours,
    output logic [MIN_W-1:0]     res_minutes,
    output logic [SEC_W-1:0]     res_seconds,
    output todoc_flags_t         flags
);

    // stage 0: input register
    logic                 s0_func_reg;
    logic [HOURS_W-1:0]   s0_ah_reg, s0_bh_reg;
    logic [MIN_W-1:0]     s0_am_reg, s0_bm_reg;
    logic [SEC_W-1:0]     s0_as_reg, s0_bs_reg;
    logic [OFF_W-1:0]     s0_off_reg;

    // stage 1: second of day of A, quotient estimate, flags
    logic [TOD_W-1:0]     s1_tod_reg, s1_tod_next;
    logic [Q_W-1:0]       s1_q_reg, s1_q_next;
    logic [OFF_W-1:0]     s1_off_reg;
    logic [2*OFF_W:0]     s1_prod;
    todoc_flags_t         s1_flags_next;

    // stage 2: wrapped tod, raw remainder
    logic [TOD_W-1:0]     s2_tod_reg, s2_tod_next;
    logic [SUM_W-1:0]     s2_rem_reg, s2_rem_next;
    logic [31:0]          s2_qd;

    // stage 3: offset mod day
    logic [TOD_W-1:0]     s3_tod_reg, s3_offd_reg, s3_offd_next;

    // stage 4: result second of day
    logic [TOD_W-1:0]     s4_r_reg, s4_r_next;
    logic [SUM_W-1:0]     s4_sum;

    // stage 5: hours and minute of day
    logic [TOD_W-1:0]     s5_r_reg;
    logic [HOURS_W-1:0]   s5_hrs_reg, s5_hrs_next;
    logic [TMIN_W-1:0]    s5_tmin_reg, s5_tmin_next;
    logic [35:0]          s5_hprod, s5_mprod;

    // stage 6: result register
    logic [HOURS_W-1:0]   s6_hrs_reg;
    logic [MIN_W-1:0]     s6_min_reg, s6_min_next;
    logic [SEC_W-1:0]     s6_sec_reg, s6_sec_next;

    logic                 func_reg [1:3];
    todoc_flags_t         flags_reg [1:6];

    always_comb
    begin
        s1_tod_next = ({12'd0, s0_ah_reg} * SEC_PER_HOUR)
                    + ({11'd0, s0_am_reg} * SEC_PER_MIN)
                    + {11'd0, s0_as_reg};
        s1_prod     = {32'd0, s0_off_reg} * {31'd0, DAY_RECIP};
        s1_q_next   = Q_W'(s1_prod >> DAY_RECIP_SH);

        s1_flags_next.a_valid = (s0_ah_reg < HOURS_PER_DAY) && (s0_am_reg < MIN_LIMIT)
                              && (s0_as_reg < SEC_LIMIT);
        if (s0_ah_reg != s0_bh_reg)
            s1_flags_next.order = (s0_ah_reg < s0_bh_reg) ? ORD_LESS : ORD_GREATER;
        else if (s0_am_reg != s0_bm_reg)
            s1_flags_next.order = (s0_am_reg < s0_bm_reg) ? ORD_LESS : ORD_GREATER;
        else if (s0_as_reg != s0_bs_reg)
            s1_flags_next.order = (s0_as_reg < s0_bs_reg) ? ORD_LESS : ORD_GREATER;
        else
            s1_flags_next.order = ORD_EQUAL;
        if (s0_ah_reg == '0)
            s1_flags_next.hour_twelve = HALF_DAY_HRS;
        else if (s0_ah_reg <= HALF_DAY_HRS)
            s1_flags_next.hour_twelve = s0_ah_reg;
        else
            s1_flags_next.hour_twelve = s0_ah_reg - HALF_DAY_HRS;
        s1_flags_next.is_pm = (s0_ah_reg >= HALF_DAY_HRS);
    end

    always_comb
    begin
        s2_tod_next = (s1_tod_reg >= SEC_PER_DAY) ? (s1_tod_reg - SEC_PER_DAY) : s1_tod_reg;
        s2_qd       = {17'd0, s1_q_reg} * {15'd0, SEC_PER_DAY};
        // estimate may be one low, so remainder is below two days
        s2_rem_next = SUM_W'({1'b0, s1_off_reg} - s2_qd);
    end

    always_comb
    begin
        if (s2_rem_reg >= {1'b0, SEC_PER_DAY})
            s3_offd_next = TOD_W'(s2_rem_reg - {1'b0, SEC_PER_DAY});
        else
            s3_offd_next = s2_rem_reg[TOD_W-1:0];
    end

    always_comb
    begin
        if (func_reg[3] == FUNC_SUB)
            s4_sum = {1'b0, s3_tod_reg} + {1'b0, SEC_PER_DAY} - {1'b0, s3_offd_reg};
        else
            s4_sum = {1'b0, s3_tod_reg} + {1'b0, s3_offd_reg};
        if (s4_sum >= {1'b0, SEC_PER_DAY})
            s4_r_next = TOD_W'(s4_sum - {1'b0, SEC_PER_DAY});
        else
            s4_r_next = s4_sum[TOD_W-1:0];
    end

    always_comb
    begin
        s5_hprod     = {19'd0, s4_r_reg} * {17'd0, HOUR_RECIP};
        s5_mprod     = {19'd0, s4_r_reg} * {17'd0, MIN_RECIP};
        s5_hrs_next  = HOURS_W'(s5_hprod >> HOUR_RECIP_SH);
        s5_tmin_next = TMIN_W'(s5_mprod >> MIN_RECIP_SH);
    end

    always_comb
    begin
        s6_min_next = MIN_W'(s5_tmin_reg - TMIN_W'({6'd0, s5_hrs_reg} * 11'd60));
        s6_sec_next = SEC_W'(s5_r_reg - TOD_W'({6'd0, s5_tmin_reg} * SEC_PER_MIN));
    end

    always_ff @(posedge clk)
    begin
        if (adv.load[0])
        begin
            s0_func_reg <= func;
            s0_ah_reg   <= a_hours;
            s0_am_reg   <= a_minutes;
            s0_as_reg   <= a_seconds;
            s0_off_reg  <= offset_seconds;
            s0_bh_reg   <= b_hours;
            s0_bm_reg   <= b_minutes;
            s0_bs_reg   <= b_seconds;
        end
        if (adv.load[1])
        begin
            s1_tod_reg   <= s1_tod_next;
            s1_q_reg     <= s1_q_next;
            s1_off_reg   <= s0_off_reg;
            func_reg[1]  <= s0_func_reg;
            flags_reg[1] <= s1_flags_next;
        end
        if (adv.load[2])
        begin
            s2_tod_reg   <= s2_tod_next;
            s2_rem_reg   <= s2_rem_next;
            func_reg[2]  <= func_reg[1];
            flags_reg[2] <= flags_reg[1];
        end
        if (adv.load[3])
        begin
            s3_tod_reg   <= s2_tod_reg;
            s3_offd_reg  <= s3_offd_next;
            func_reg[3]  <= func_reg[2];
            flags_reg[3] <= flags_reg[2];
        end
        if (adv.load[4])
        begin
            s4_r_reg     <= s4_r_next;
            flags_reg[4] <= flags_reg[3];
        end
        if (adv.load[5])
        begin
            s5_r_reg     <= s4_r_reg;
            s5_hrs_reg   <= s5_hrs_next;
            s5_tmin_reg  <= s5_tmin_next;
            flags_reg[5] <= flags_reg[4];
        end
        if (adv.load[6])
        begin
            s6_hrs_reg   <= s5_hrs_reg;
            s6_min_reg   <= s6_min_next;
            s6_sec_reg   <= s6_sec_next;
            flags_reg[6] <= flags_reg[5];
        end
    end

    assign res_hours   = s6_hrs_reg;
    assign res_minutes = s6_min_reg;
    assign res_seconds = s6_sec_reg;
    assign flags       = flags_reg[6];

endmodule
